// ===== rtl/core/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types and constants of the filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

   localparam int DEFAULT_MAX_RADIUS      = 88;
   localparam int DEFAULT_JOB_QUEUE_DEPTH = 2;

   localparam int CENTER_W    = 11;
   localparam int RADIUS_W    = 7;
   localparam int COORD_W     = 13;
   localparam int OFFSET_W    = 8;
   localparam int DECISION_W  = 11;
   localparam int GROUP_LIMIT = 64;
   localparam int GROUP_CNT_W = 6;

   typedef struct packed {
      logic [CENTER_W-1:0]          center_x;
      logic [CENTER_W-1:0]          center_y;
      logic [RADIUS_W-1:0]          radius;
      logic signed [DECISION_W-1:0] decision;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/core/fcsg_job_queue.sv =====
// ----------------------------------------------------------------------------
// fcsg_job_queue
// Short register queue of prepared circle jobs between front and back.
// ----------------------------------------------------------------------------
module fcsg_job_queue #(
   parameter int DEPTH = fcsg_pkg::DEFAULT_JOB_QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  fcsg_pkg::job_type            push_job,
   input  logic                         pop,
   output fcsg_pkg::job_type            head_job,
   output fcsg_pkg::queue_status_type   status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fcsg_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/fcsg_front.sv =====
// ----------------------------------------------------------------------------
// fcsg_front
// Accepts circle requests, caps the radius and prepares the start decision.
// ----------------------------------------------------------------------------
module fcsg_front #(
   parameter int MAX_RADIUS = fcsg_pkg::DEFAULT_MAX_RADIUS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [fcsg_pkg::CENTER_W-1:0]     req_center_x,
   input  logic [fcsg_pkg::CENTER_W-1:0]     req_center_y,
   input  logic [fcsg_pkg::RADIUS_W-1:0]     req_radius,
   input  fcsg_pkg::queue_status_type        queue_status,
   output logic                              queue_push,
   output fcsg_pkg::job_type                 queue_job
);

   logic                              valid_ff, valid_in;
   fcsg_pkg::job_type                 job_ff, job_in;
   logic [fcsg_pkg::RADIUS_W-1:0]     radius_capped;
   logic                              accept;

   assign req_full   = valid_ff && queue_status.full;
   assign accept     = req_push && !req_full;
   assign queue_push = valid_ff && !queue_status.full;
   assign queue_job  = job_ff;

   always_comb begin
      radius_capped = (req_radius > fcsg_pkg::RADIUS_W'(MAX_RADIUS))
                    ? fcsg_pkg::RADIUS_W'(MAX_RADIUS) : req_radius;
      job_in.center_x = req_center_x;
      job_in.center_y = req_center_y;
      job_in.radius   = radius_capped;
      job_in.decision = signed'(fcsg_pkg::DECISION_W'(3))
                      - signed'({3'b000, radius_capped, 1'b0});
      valid_in = accept || (valid_ff && !queue_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

// ===== rtl/core/fcsg_back.sv =====
// ----------------------------------------------------------------------------
// fcsg_back
// Runs the midpoint circle loop into an output register, one span group per
// cycle while results are popped.
// ----------------------------------------------------------------------------
module fcsg_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fcsg_pkg::job_type                     head_job,
   input  fcsg_pkg::queue_status_type            queue_status,
   output logic                                  queue_pop,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_near_left_x,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_near_right_x,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_far_top_y,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_far_bottom_y,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_far_left_x,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_far_right_x,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_near_top_y,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_near_bottom_y,
   output logic                                  rsp_last_group
);

   localparam int CW = fcsg_pkg::COORD_W;
   localparam int OW = fcsg_pkg::OFFSET_W;
   localparam int DW = fcsg_pkg::DECISION_W;

   logic                                busy_ff, busy_in;
   logic [fcsg_pkg::CENTER_W-1:0]       cx_ff, cy_ff;
   logic signed [OW-1:0]                a_ff, a_in, b_ff, b_in;
   logic signed [DW-1:0]                d_ff, d_in;
   logic [fcsg_pkg::GROUP_CNT_W-1:0]    n_ff, n_in;
   logic                                out_valid_ff, out_valid_in;
   logic                                load, emit, last;
   logic signed [OW-1:0]                a_next, b_next;
   logic signed [DW-1:0]                d_next, a_ext, diff_ext;
   logic signed [CW-1:0]                cx_s, cy_s, a_s, b_s;

   assign load      = !busy_ff && !queue_status.empty;
   assign queue_pop = load;
   assign emit      = busy_ff && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      a_ext    = DW'(a_ff);
      diff_ext = DW'(a_ff - b_ff);
      a_next   = a_ff + OW'(1);
      if (d_ff < 0) begin
         d_next = d_ff + (a_ext <<< 2) + DW'(6);
         b_next = b_ff;
      end else begin
         d_next = d_ff + (diff_ext <<< 2) + DW'(10);
         b_next = b_ff - OW'(1);
      end
      last = (a_next > b_next)
          || (n_ff == fcsg_pkg::GROUP_CNT_W'(fcsg_pkg::GROUP_LIMIT - 1));

      cx_s = signed'({2'b00, cx_ff});
      cy_s = signed'({2'b00, cy_ff});
      a_s  = CW'(a_ff);
      b_s  = CW'(b_ff);

      busy_in      = busy_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (load) begin
         busy_in = 1'b1;
         a_in    = '0;
         b_in    = signed'({1'b0, head_job.radius});
         d_in    = head_job.decision;
         n_in    = '0;
      end else if (emit) begin
         busy_in = !last;
         a_in    = a_next;
         b_in    = b_next;
         d_in    = d_next;
         n_in    = n_ff + 1'b1;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      d_ff <= d_in;
      n_ff <= n_in;
      if (load) begin
         cx_ff <= head_job.center_x;
         cy_ff <= head_job.center_y;
      end
      if (emit) begin
         rsp_near_left_x   <= cx_s - a_s;
         rsp_near_right_x  <= cx_s + a_s;
         rsp_far_top_y     <= cy_s - b_s;
         rsp_far_bottom_y  <= cy_s + b_s;
         rsp_far_left_x    <= cx_s - b_s;
         rsp_far_right_x   <= cx_s + b_s;
         rsp_near_top_y    <= cy_s - a_s;
         rsp_near_bottom_y <= cy_s + a_s;
         rsp_last_group    <= last;
      end
   end

   // While a circle is being walked the x offset never passes the y offset.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (a_ff <= b_ff))
      else $error("x offset passed y offset during a walk");

   assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> !busy_ff)
      else $error("walk continued after its final group");

   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !load) |-> !queue_pop)
      else $error("job taken from the queue while a walk is running");

   assert property (@(posedge clock) disable iff (reset)
      (emit && !last) |=> busy_ff)
      else $error("walk stopped before its final group");

endmodule

// ===== rtl/core/filled_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Midpoint circle walker that turns a circle request into span groups, each
// holding the four horizontal spans that fill one step of the circle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  req_      in         req_push / req_full   center_x, center_y, radius
//  rsp_      out        rsp_empty / rsp_pop   eight span coordinates, last_group
//
//  Each circle yields one group per x offset up to the y offset, about
//  r / sqrt(2) + 1, at one per cycle while results are popped; a radius of 88
//  gives 63 groups. A result left waiting holds the walk, and the walk pauses
//  between circles while the next job is loaded. Requests are taken while
//  earlier circles are walked, until the job queue and front register are
//  both occupied; reset is synchronous.
// ----------------------------------------------------------------------------
module filled_circle_span_generator #(
   parameter int MAX_RADIUS      = fcsg_pkg::DEFAULT_MAX_RADIUS,
   parameter int JOB_QUEUE_DEPTH = fcsg_pkg::DEFAULT_JOB_QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [fcsg_pkg::CENTER_W-1:0]         req_center_x,
   input  logic [fcsg_pkg::CENTER_W-1:0]         req_center_y,
   input  logic [fcsg_pkg::RADIUS_W-1:0]         req_radius,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_near_left_x,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_near_right_x,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_far_top_y,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_far_bottom_y,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_far_left_x,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_far_right_x,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_near_top_y,
   output logic signed [fcsg_pkg::COORD_W-1:0]   rsp_near_bottom_y,
   output logic                                  rsp_last_group
);

   fcsg_pkg::job_type            push_job, head_job;
   fcsg_pkg::queue_status_type   queue_status;
   logic                         queue_push, queue_pop;

   fcsg_front #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .queue_status (queue_status),
      .queue_push   (queue_push),
      .queue_job    (push_job)
   );

   fcsg_job_queue #(
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_job (push_job),
      .pop      (queue_pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   fcsg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .queue_status      (queue_status),
      .queue_pop         (queue_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_near_left_x   (rsp_near_left_x),
      .rsp_near_right_x  (rsp_near_right_x),
      .rsp_far_top_y     (rsp_far_top_y),
      .rsp_far_bottom_y  (rsp_far_bottom_y),
      .rsp_far_left_x    (rsp_far_left_x),
      .rsp_far_right_x   (rsp_far_right_x),
      .rsp_near_top_y    (rsp_near_top_y),
      .rsp_near_bottom_y (rsp_near_bottom_y),
      .rsp_last_group    (rsp_last_group)
   );

endmodule

// ===== tb/sv/tb_filled_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// tb_filled_circle_span_generator
// Self-checking bench for the filled circle span generator. Circle requests
// are fed through the request queue with random gaps, every span group is
// predicted by walking the midpoint circle here, and each group popped from
// the result queue is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_filled_circle_span_generator;

   timeunit 1ns;
   timeprecision 1ps;

   import fcsg_pkg::*;

   localparam int MAX_RADIUS  = DEFAULT_MAX_RADIUS;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int DRAIN_WAIT  = 200;
   localparam int RANDOM_ITEMS = 350;
   localparam int SIDE_REQ    = 0;
   localparam int SIDE_RSP    = 1;

   typedef struct {
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [RADIUS_W-1:0] radius;
   } circle_type;

   typedef struct {
      logic [COORD_W-1:0] near_left_x;
      logic [COORD_W-1:0] near_right_x;
      logic [COORD_W-1:0] far_top_y;
      logic [COORD_W-1:0] far_bottom_y;
      logic [COORD_W-1:0] far_left_x;
      logic [COORD_W-1:0] far_right_x;
      logic [COORD_W-1:0] near_top_y;
      logic [COORD_W-1:0] near_bottom_y;
      logic               last_group;
   } span_group_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [CENTER_W-1:0]        req_center_x = '0;
   logic [CENTER_W-1:0]        req_center_y = '0;
   logic [RADIUS_W-1:0]        req_radius = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic signed [COORD_W-1:0]  rsp_near_left_x;
   logic signed [COORD_W-1:0]  rsp_near_right_x;
   logic signed [COORD_W-1:0]  rsp_far_top_y;
   logic signed [COORD_W-1:0]  rsp_far_bottom_y;
   logic signed [COORD_W-1:0]  rsp_far_left_x;
   logic signed [COORD_W-1:0]  rsp_far_right_x;
   logic signed [COORD_W-1:0]  rsp_near_top_y;
   logic signed [COORD_W-1:0]  rsp_near_bottom_y;
   logic                       rsp_last_group;

   circle_type     pending_circles[$];
   span_group_type expected_groups[$];

   int error_count    = 0;
   int circle_count   = 0;
   int capped_count   = 0;
   int group_count    = 0;
   int final_count    = 0;
   int cycle_count    = 0;
   int request_gap    = 0;
   int response_stall = 0;
   int calm_left[2]   = '{0, 0};

   filled_circle_span_generator #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius        (req_radius),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_near_left_x   (rsp_near_left_x),
      .rsp_near_right_x  (rsp_near_right_x),
      .rsp_far_top_y     (rsp_far_top_y),
      .rsp_far_bottom_y  (rsp_far_bottom_y),
      .rsp_far_left_x    (rsp_far_left_x),
      .rsp_far_right_x   (rsp_far_right_x),
      .rsp_near_top_y    (rsp_near_top_y),
      .rsp_near_bottom_y (rsp_near_bottom_y),
      .rsp_last_group    (rsp_last_group)
   );

   always #5 clock = ~clock;

   // Mostly short gaps with the odd long one; now and then a side runs for a
   // while with no idling at all.
   function automatic int draw_gap(input int side);
      int pick;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left[side] = $urandom_range(20, 120);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic void walk_circle(input circle_type c);
      int cx;
      int cy;
      int a;
      int b;
      int d;
      int n;
      span_group_type g;
      cx = c.center_x;
      cy = c.center_y;
      b  = (c.radius > MAX_RADIUS) ? MAX_RADIUS : int'(c.radius);
      d  = 3 - 2 * b;
      a  = 0;
      n  = 0;
      while (a <= b && n < GROUP_LIMIT) begin
         g.near_left_x   = COORD_W'(cx - a);
         g.near_right_x  = COORD_W'(cx + a);
         g.far_top_y     = COORD_W'(cy - b);
         g.far_bottom_y  = COORD_W'(cy + b);
         g.far_left_x    = COORD_W'(cx - b);
         g.far_right_x   = COORD_W'(cx + b);
         g.near_top_y    = COORD_W'(cy - a);
         g.near_bottom_y = COORD_W'(cy + a);
         if (d < 0) begin
            d += 4 * a + 6;
         end else begin
            d += 4 * (a - b) + 10;
            b--;
         end
         a++;
         n++;
         g.last_group = (a > b) || (n == GROUP_LIMIT);
         expected_groups.push_back(g);
      end
   endfunction

   task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         error_count++;
      end
   endtask

   task automatic add_circle(input int cx, input int cy, input int r);
      circle_type c;
      c.center_x = CENTER_W'(cx);
      c.center_y = CENTER_W'(cy);
      c.radius   = RADIUS_W'(r);
      pending_circles.push_back(c);
   endtask

   // Request driver.
   always @(posedge clock) begin
      circle_type c;
      if (reset) begin
         req_push <= 1'b0;
      end else if (!(req_push && req_full)) begin
         if (req_push) begin
            c.center_x = req_center_x;
            c.center_y = req_center_y;
            c.radius   = req_radius;
            walk_circle(c);
            circle_count++;
            if (c.radius > MAX_RADIUS) capped_count++;
            request_gap = draw_gap(SIDE_REQ);
         end
         if (request_gap > 0) begin
            request_gap--;
            req_push <= 1'b0;
         end else if (pending_circles.size() > 0) begin
            c = pending_circles.pop_front();
            req_center_x <= c.center_x;
            req_center_y <= c.center_y;
            req_radius   <= c.radius;
            req_push     <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      span_group_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            group_count++;
            if (rsp_last_group) final_count++;
            if (expected_groups.size() == 0) begin
               $error("span group popped with no prediction waiting");
               error_count++;
            end else begin
               want = expected_groups.pop_front();
               check_field("near_left_x",   want.near_left_x,   rsp_near_left_x);
               check_field("near_right_x",  want.near_right_x,  rsp_near_right_x);
               check_field("far_top_y",     want.far_top_y,     rsp_far_top_y);
               check_field("far_bottom_y",  want.far_bottom_y,  rsp_far_bottom_y);
               check_field("far_left_x",    want.far_left_x,    rsp_far_left_x);
               check_field("far_right_x",   want.far_right_x,   rsp_far_right_x);
               check_field("near_top_y",    want.near_top_y,    rsp_near_top_y);
               check_field("near_bottom_y", want.near_bottom_y, rsp_near_bottom_y);
               check_field("last_group",    COORD_W'(want.last_group),
                           COORD_W'(rsp_last_group));
            end
            response_stall = draw_gap(SIDE_RSP);
         end
         if (response_stall > 0) begin
            response_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int pick;
      int r;
      // Corners of the coordinate range, the zero radius, the cap and the
      // radii above it, and alternating bit patterns.
      add_circle(0, 0, 0);
      add_circle(2047, 2047, 0);
      add_circle(0, 0, 88);
      add_circle(2047, 2047, 88);
      add_circle(0, 2047, 127);
      add_circle(2047, 0, 89);
      add_circle(1024, 1024, 1);
      add_circle(1024, 1024, 2);
      add_circle(1024, 1024, 3);
      add_circle(1024, 1024, 4);
      add_circle(12'h555, 12'h2AA, 85);
      add_circle(12'h2AA, 12'h555, 42);
      add_circle(5, 7, 10);
      add_circle(100, 2000, 64);
      add_circle(2040, 3, 120);
      add_circle(0, 0, 1);
      add_circle(2047, 2047, 1);
      add_circle(44, 44, 44);
      add_circle(87, 87, 87);
      add_circle(1, 2046, 100);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            r = $urandom_range(0, 15);
         end else if (pick < 8) begin
            r = $urandom_range(0, 127);
         end else begin
            r = $urandom_range(80, 127);
         end
         add_circle($urandom_range(0, 2047), $urandom_range(0, 2047), r);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
      end while (pending_circles.size() != 0 || req_push || expected_groups.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Checked %0d circles (%0d with the radius above the cap).",
               circle_count, capped_count);
      $display("Compared %0d span groups, %0d of them closing a circle.",
               group_count, final_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
